// ===== src/mbrw_pkg.sv =====
// Shared types and constants of the boot-record partition walker.
`default_nettype none
package mbrw_pkg;

  localparam int MBR_RECORDS  = 4;
  localparam int EBR_RECORDS  = 2;
  localparam int REC_BYTES    = 16;
  localparam int TABLE_OFFSET = 446;
  localparam int TABLE_SPAN   = REC_BYTES * MBR_RECORDS;
  localparam int SIG_OFFSET   = 510;
  localparam int REC_IDX_W    = $clog2(MBR_RECORDS);

  localparam logic [15:0] BOOT_SIG   = 16'hAA55;
  localparam logic [7:0]  EXT_CHS    = 8'h05;
  localparam logic [7:0]  EXT_LBA    = 8'h0F;
  localparam logic [7:0]  TYPE_EMPTY = 8'h00;
  localparam int          ACTIVE_BIT = 7;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_BADSIG = 2'd3
  } kind_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  ptype;
    logic [31:0] lba;
    logic [31:0] count;
  } rec_t;

  typedef struct packed {
    logic sector_end;
    logic sig_ok;
  } cap_status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  entry_type;
    logic        active;
    logic        primary;
    logic [33:0] start_sector;
    logic [31:0] size_sectors;
    logic [32:0] next_sector;
    logic [7:0]  part_count;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== src/mbrw_capture.sv =====
// Byte counter and capture of the partition records and boot signature.
`default_nettype none
module mbrw_capture import mbrw_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           sector_byte,
  input  wire logic [REC_IDX_W-1:0] rd_idx,
  output rec_t                      rec,
  output cap_status_t               status
);

  localparam int OFF_W = $clog2(SECTOR_BYTES);
  localparam int REL_W = $clog2(TABLE_SPAN);

  logic [OFF_W-1:0] byte_offset;
  logic [7:0]       signature_low;
  logic [7:0]       signature_high;
  rec_t             record_store [MBR_RECORDS];

  logic             at_end;
  logic             in_table;
  logic [OFF_W-1:0] rel_full;
  logic [REL_W-1:0] rel;
  logic [REC_IDX_W-1:0] wr_idx;
  logic [3:0]       pos;

  assign at_end   = byte_offset == OFF_W'(SECTOR_BYTES - 1);
  assign in_table = (byte_offset >= OFF_W'(TABLE_OFFSET)) &&
                    (byte_offset < OFF_W'(TABLE_OFFSET + TABLE_SPAN));
  assign rel_full = byte_offset - OFF_W'(TABLE_OFFSET);
  assign rel      = rel_full[REL_W-1:0];
  assign wr_idx   = rel[REL_W-1:4];
  assign pos      = rel[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (accept) begin
      byte_offset <= at_end ? '0 : byte_offset + OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_offset == OFF_W'(SIG_OFFSET)) begin
        signature_low <= sector_byte;
      end
      if (byte_offset == OFF_W'(SIG_OFFSET + 1)) begin
        signature_high <= sector_byte;
      end
      if (in_table) begin
        case (pos) inside
          4'd0:          record_store[wr_idx].active <= sector_byte[ACTIVE_BIT];
          4'd4:          record_store[wr_idx].ptype <= sector_byte;
          [4'd8:4'd11]:  record_store[wr_idx].lba[8*pos[1:0] +: 8] <= sector_byte;
          [4'd12:4'd15]: record_store[wr_idx].count[8*pos[1:0] +: 8] <= sector_byte;
          default: ;
        endcase
      end
    end
  end

  assign rec               = record_store[rd_idx];
  assign status.sector_end = accept && at_end;
  assign status.sig_ok     = {signature_high, signature_low} == BOOT_SIG;

endmodule
`default_nettype wire

// ===== src/mbrw_scan.sv =====
// Record scan sequencer with the shared sector adder and the result register.
`default_nettype none
module mbrw_scan import mbrw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [7:0]           cfg_data,
  input  cap_status_t               status,
  input  rec_t                      rec,
  output logic [REC_IDX_W-1:0]      rd_idx,
  output logic                      idle,
  output res_t                      res,
  output logic                      res_valid,
  input  wire logic                 res_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [REC_IDX_W-1:0] idx, idx_next;
  logic [32:0]          current_sector, current_sector_next;
  logic [32:0]          first_ebr_sector, first_ebr_sector_next;
  logic [32:0]          link_sector, link_sector_next;
  logic                 in_ebr, in_ebr_next;
  logic [7:0]           found_count, found_count_next;
  logic                 limit_hit, limit_hit_next;
  logic [7:0]           max_parts;
  res_t                 res_next;
  logic                 load;

  logic                 free;
  logic                 is_empty;
  logic                 is_ext;
  logic [33:0]          add_a;
  logic [33:0]          sum;
  logic [7:0]           found_inc;
  logic [REC_IDX_W-1:0] last_idx;
  logic                 emit_entry;

  assign free       = !res_valid || res_ready;
  assign is_empty   = rec.ptype == TYPE_EMPTY;
  assign is_ext     = (rec.ptype == EXT_CHS) || (rec.ptype == EXT_LBA);
  assign add_a      = is_ext ? {1'b0, first_ebr_sector} : {1'b0, current_sector};
  assign sum        = add_a + {2'b00, rec.lba};
  assign found_inc  = (found_count != 8'hFF) ? found_count + 8'd1 : found_count;
  assign last_idx   = in_ebr ? REC_IDX_W'(EBR_RECORDS - 1) : REC_IDX_W'(MBR_RECORDS - 1);
  assign emit_entry = !is_empty && !is_ext && (max_parts != 8'd0);
  assign rd_idx     = idx;
  assign idle       = state == S_IDLE;

  always_comb begin
    state_next            = state;
    idx_next              = idx;
    current_sector_next   = current_sector;
    first_ebr_sector_next = first_ebr_sector;
    link_sector_next      = link_sector;
    in_ebr_next           = in_ebr;
    found_count_next      = found_count;
    limit_hit_next        = limit_hit;
    load                  = 1'b0;
    res_next              = '0;
    res_next.kind         = KIND_ENTRY;
    res_next.part_count   = found_count;

    case (state)
      S_IDLE: begin
        if (status.sector_end) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.sig_ok) begin
          if (free) begin
            load                  = 1'b1;
            res_next.kind         = KIND_BADSIG;
            res_next.last         = 1'b1;
            current_sector_next   = '0;
            first_ebr_sector_next = '0;
            link_sector_next      = '0;
            in_ebr_next           = 1'b0;
            found_count_next      = '0;
            state_next            = S_IDLE;
          end
        end else begin
          link_sector_next = '0;
          limit_hit_next   = 1'b0;
          idx_next         = '0;
          state_next       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!emit_entry || free) begin
          if (idx == last_idx) begin
            state_next = S_FINAL;
          end else begin
            idx_next = idx + REC_IDX_W'(1);
          end
          if (is_empty) begin
            if (in_ebr) begin
              link_sector_next = '0;
              state_next       = S_FINAL;
            end
          end else if (is_ext) begin
            link_sector_next = sum[32:0];
          end else begin
            found_count_next = found_inc;
            if (max_parts != 8'd0) begin
              load                  = 1'b1;
              res_next.kind         = KIND_ENTRY;
              res_next.entry_type   = rec.ptype;
              res_next.active       = rec.active;
              res_next.primary      = !in_ebr;
              res_next.start_sector = sum;
              res_next.size_sectors = rec.count;
              res_next.part_count   = found_inc;
              if (found_inc >= max_parts) begin
                limit_hit_next = 1'b1;
                state_next     = S_FINAL;
              end
            end
          end
        end
      end
      S_FINAL: begin
        if (free) begin
          load          = 1'b1;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
          if ((link_sector != '0) && !limit_hit) begin
            res_next.kind        = KIND_FETCH;
            res_next.next_sector = link_sector;
            if (!in_ebr) begin
              first_ebr_sector_next = link_sector;
            end
            current_sector_next = link_sector;
            in_ebr_next         = 1'b1;
          end else begin
            res_next.kind         = KIND_DONE;
            current_sector_next   = '0;
            first_ebr_sector_next = '0;
            link_sector_next      = '0;
            in_ebr_next           = 1'b0;
            found_count_next      = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      idx              <= '0;
      current_sector   <= '0;
      first_ebr_sector <= '0;
      link_sector      <= '0;
      in_ebr           <= 1'b0;
      found_count      <= '0;
      limit_hit        <= 1'b0;
      max_parts        <= '0;
      res_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      idx              <= idx_next;
      current_sector   <= current_sector_next;
      first_ebr_sector <= first_ebr_sector_next;
      link_sector      <= link_sector_next;
      in_ebr           <= in_ebr_next;
      found_count      <= found_count_next;
      limit_hit        <= limit_hit_next;
      if (cfg_write) begin
        max_parts <= cfg_data;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mbr_ebr_partition_walker_core.sv =====
// Top level of the MBR/EBR partition walker.
// Sector bytes are taken one per cycle while in_ready is high, offsets 0 to
// SECTOR_BYTES-1 in order, starting with the MBR at sector 0. After the last
// byte of a sector in_ready drops while the sequencer checks the signature and
// walks the records through the shared sector adder, one record per cycle
// while the result register is free (up to 4 for the MBR, 2 for an EBR), then
// issues the closing word; in_ready also stays low while the sequencer waits
// on out_ready. Each sector yields zero or more entry words followed by one
// fetch, done or bad-signature word with last set; a fetch word names the
// sector to feed next. max_parts is to be written by the user through the
// cfg channel only while the block is idle, which the block does not enforce.
`default_nettype none
module mbr_ebr_partition_walker_core import mbrw_pkg::*; #(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  max_parts,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sector_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       entry_type,
  output logic             active,
  output logic             primary,
  output logic [33:0]      start_sector,
  output logic [31:0]      size_sectors,
  output logic [32:0]      next_sector,
  output logic [7:0]       part_count,
  output logic             last
);

  logic                 accept;
  logic                 idle;
  logic [REC_IDX_W-1:0] rd_idx;
  rec_t                 rec;
  cap_status_t          status;
  res_t                 res;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign accept    = in_valid && in_ready;

  mbrw_capture #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sector_byte (sector_byte),
    .rd_idx      (rd_idx),
    .rec         (rec),
    .status      (status)
  );

  mbrw_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (max_parts),
    .status    (status),
    .rec       (rec),
    .rd_idx    (rd_idx),
    .idle      (idle),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign kind         = res.kind;
  assign entry_type   = res.entry_type;
  assign active       = res.active;
  assign primary      = res.primary;
  assign start_sector = res.start_sector;
  assign size_sectors = res.size_sectors;
  assign next_sector  = res.next_sector;
  assign part_count   = res.part_count;
  assign last         = res.last;

endmodule
`default_nettype wire

// ===== src/mbrw_checker.sv =====
// Port-level checks of the partition walker and their bind to the top level.
`default_nettype none
module mbrw_checker import mbrw_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  entry_type,
  input wire logic [33:0] start_sector,
  input wire logic [31:0] size_sectors,
  input wire logic [32:0] next_sector,
  input wire logic [7:0]  part_count,
  input wire logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start_sector)
      && $stable(part_count) && $stable(last))
    else $error("result word changed while stalled");

  a_busy_after_byte: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input stalled without a preceding byte");

  a_entry_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENTRY |-> !last && part_count != 8'd0)
    else $error("entry word flagged last or with zero count");

  a_closing_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ENTRY |-> last && entry_type == 8'd0
      && start_sector == 34'd0 && size_sectors == 32'd0
      && (kind == KIND_FETCH || next_sector == 33'd0))
    else $error("malformed closing word");

endmodule

bind mbr_ebr_partition_walker_core mbrw_checker u_mbrw_checker (.*);
`default_nettype wire
